// ===== hdl/kqrl_pkg.sv =====
// ----------------------------------------------------------------------------
// kqrl_pkg: shared definitions for the keyed quota and rate limit table
// Field widths, operation and status codes, window length and the layout
// of one stored record.
// ----------------------------------------------------------------------------
`default_nettype none

package kqrl_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 64;
    localparam int QUOTA_W  = 64;
    localparam int RATE_W   = 20;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
    localparam logic [OP_W-1:0] OP_QUOTA  = 3'd3;
    localparam logic [OP_W-1:0] OP_RATE   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    localparam logic [TIME_W-1:0] WINDOW_SECONDS = 32'd60;

    // one table entry apart from its key
    typedef struct packed {
        logic [QUOTA_W-1:0] quota;
        logic [QUOTA_W-1:0] usage;
        logic [RATE_W-1:0]  rate;
        logic [TIME_W-1:0]  wstart;
        logic [RATE_W-1:0]  wcount;
    } rec_t;

endpackage

`default_nettype wire

// ===== hdl/kqrl_ram.sv =====
// ----------------------------------------------------------------------------
// kqrl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kqrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/keyed_quota_and_rate_limit_table.sv =====
// ----------------------------------------------------------------------------
// keyed_quota_and_rate_limit_table: keyed token quota and rate limit table
// Entries found by linear key search; per-entry quota, usage and a fixed
// 60 s request window, held in two synchronous RAMs.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  s_       | in        | s_valid / s_ready  | operation, key, quota_limit,
//           |           |                    | rate_limit, initial_usage,
//           |           |                    | tokens, now_seconds
//  m_       | out       | m_valid / m_ready  | status, allowed
//
//  Flow: one item at a time. The search reads one stored key per cycle
//  from the key RAM's single read port, comparing up to the live entry
//  count of keys. Bad operations and create with key zero skip the search.
//  Reset: clears the entry count and the control state only; RAM contents
//  are left as they are, as slots at or above the count are never read.
//  Stalls: the result sits in an output register, so a new item is taken
//  while a result waits; a finished item holds until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_quota_and_rate_limit_table #(
    parameter int TABLE_DEPTH = kqrl_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [kqrl_pkg::OP_W-1:0]     s_operation,
    input  wire logic [kqrl_pkg::KEY_W-1:0]    s_key,
    input  wire logic [kqrl_pkg::QUOTA_W-1:0]  s_quota_limit,
    input  wire logic [kqrl_pkg::RATE_W-1:0]   s_rate_limit,
    input  wire logic [kqrl_pkg::QUOTA_W-1:0]  s_initial_usage,
    input  wire logic [kqrl_pkg::QUOTA_W-1:0]  s_tokens,
    input  wire logic [kqrl_pkg::TIME_W-1:0]   s_now_seconds,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [kqrl_pkg::STATUS_W-1:0] m_status,
    output logic                               m_allowed
);

    localparam int AW    = $clog2(TABLE_DEPTH);      // slot index
    localparam int CW    = $clog2(TABLE_DEPTH + 1);  // entry count
    localparam int REC_W = $bits(kqrl_pkg::rec_t);

    // controller states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SRCH   = 3'd1;  // key scan, one read per cycle
    localparam logic [2:0] S_RDLAST = 3'd2;  // delete: fetch last entry
    localparam logic [2:0] S_CPY    = 3'd3;  // delete: move last into hole
    localparam logic [2:0] S_RREC   = 3'd4;  // fetch record of found entry
    localparam logic [2:0] S_MOD    = 3'd5;  // modify and write back
    localparam logic [2:0] S_RESP   = 3'd6;  // hand result to output reg

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] issue_reg, issue_next;     // next slot to read in scan
    logic          cmp_vld_reg, cmp_vld_next; // a key read is returning
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next; // slot of the returning key
    logic [AW-1:0] fnd_idx_reg, fnd_idx_next;

    logic [kqrl_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                          res_allowed_reg, res_allowed_next;

    logic                          m_valid_reg, m_valid_next;
    logic [kqrl_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic                          m_allowed_reg, m_allowed_next;

    // captured request
    logic [kqrl_pkg::OP_W-1:0]    op_reg;
    logic [kqrl_pkg::KEY_W-1:0]   key_reg;
    logic [kqrl_pkg::QUOTA_W-1:0] quota_reg;
    logic [kqrl_pkg::RATE_W-1:0]  rate_reg;
    logic [kqrl_pkg::QUOTA_W-1:0] init_reg;
    logic [kqrl_pkg::QUOTA_W-1:0] tokens_reg;
    logic [kqrl_pkg::TIME_W-1:0]  now_reg;

    // RAM ports
    logic                       key_we, key_re;
    logic [AW-1:0]              key_waddr, key_raddr;
    logic [kqrl_pkg::KEY_W-1:0] key_wdata, key_rdata;
    logic                       rec_we, rec_re;
    logic [AW-1:0]              rec_waddr, rec_raddr;
    kqrl_pkg::rec_t             rec_wdata, rec_rdata;
    logic [REC_W-1:0]           rec_rbits;

    logic                         s_xfer;
    logic [CW-1:0]                last_idx;
    logic                         hit;
    logic [kqrl_pkg::TIME_W-1:0]  elapsed;
    kqrl_pkg::rec_t               rec_mod;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_allowed = m_allowed_reg;

    assign last_idx  = total_reg - CW'(1);
    assign hit       = cmp_vld_reg && (key_rdata == key_reg);
    assign rec_rdata = kqrl_pkg::rec_t'(rec_rbits);
    assign elapsed   = now_reg - rec_rdata.wstart;

    kqrl_ram #(
        .WIDTH (kqrl_pkg::KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (key_waddr),
        .wr_data (key_wdata),
        .rd_en   (key_re),
        .rd_addr (key_raddr),
        .rd_data (key_rdata)
    );

    kqrl_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (rec_we),
        .wr_addr (rec_waddr),
        .wr_data (rec_wdata),
        .rd_en   (rec_re),
        .rd_addr (rec_raddr),
        .rd_data (rec_rbits)
    );

    // Modified record for add usage and check rate; allowed flag alongside.
    always_comb begin
        rec_mod          = rec_rdata;
        res_allowed_next = 1'b0;
        case (op_reg)
            kqrl_pkg::OP_ADD: begin
                rec_mod.usage = rec_rdata.usage + tokens_reg;
            end
            kqrl_pkg::OP_QUOTA: begin
                res_allowed_next = (rec_rdata.quota == '0) ||
                                   (rec_rdata.usage < rec_rdata.quota);
            end
            kqrl_pkg::OP_RATE: begin
                if (rec_rdata.rate == '0) begin
                    res_allowed_next = 1'b1;
                end else begin
                    if (elapsed >= kqrl_pkg::WINDOW_SECONDS) begin
                        rec_mod.wstart = now_reg;
                        rec_mod.wcount = '0;
                    end
                    if (rec_mod.wcount < rec_rdata.rate) begin
                        rec_mod.wcount   = rec_mod.wcount + kqrl_pkg::RATE_W'(1);
                        res_allowed_next = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        total_next      = total_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        fnd_idx_next    = fnd_idx_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_allowed_next  = m_allowed_reg;

        key_we    = 1'b0;
        key_waddr = total_reg[AW-1:0];
        key_wdata = key_reg;
        key_re    = 1'b0;
        key_raddr = issue_reg[AW-1:0];
        rec_we    = 1'b0;
        rec_waddr = total_reg[AW-1:0];
        rec_wdata = '{quota: quota_reg, usage: init_reg, rate: rate_reg,
                      wstart: '0, wcount: '0};
        rec_re    = 1'b0;
        rec_raddr = fnd_idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    issue_next = '0;
                    if (s_operation > kqrl_pkg::OP_RATE) begin
                        res_status_next = kqrl_pkg::ST_INVALID;
                        state_next      = S_RESP;
                    end else if (s_operation == kqrl_pkg::OP_CREATE && s_key == '0) begin
                        res_status_next = kqrl_pkg::ST_INVALID;
                        state_next      = S_RESP;
                    end else begin
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH: begin
                if (hit) begin
                    fnd_idx_next = cmp_idx_reg;
                    case (op_reg)
                        kqrl_pkg::OP_CREATE: begin
                            res_status_next = kqrl_pkg::ST_EXISTS;
                            state_next      = S_RESP;
                        end
                        kqrl_pkg::OP_DELETE: state_next = S_RDLAST;
                        default:             state_next = S_RREC;
                    endcase
                end else if (issue_reg == total_reg) begin
                    // every live key compared, none matched
                    state_next = S_RESP;
                    if (op_reg == kqrl_pkg::OP_CREATE) begin
                        if (total_reg == CW'(TABLE_DEPTH)) begin
                            res_status_next = kqrl_pkg::ST_FULL;
                        end else begin
                            key_we          = 1'b1;
                            rec_we          = 1'b1;
                            total_next      = total_reg + CW'(1);
                            res_status_next = kqrl_pkg::ST_OK;
                        end
                    end else begin
                        res_status_next = kqrl_pkg::ST_NOT_FOUND;
                    end
                end else begin
                    key_re       = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[AW-1:0];
                    issue_next   = issue_reg + CW'(1);
                end
            end
            S_RDLAST: begin
                key_re     = 1'b1;
                key_raddr  = last_idx[AW-1:0];
                rec_re     = 1'b1;
                rec_raddr  = last_idx[AW-1:0];
                state_next = S_CPY;
            end
            S_CPY: begin
                key_waddr = fnd_idx_reg;
                key_wdata = key_rdata;
                rec_waddr = fnd_idx_reg;
                rec_wdata = rec_rdata;
                if (CW'(fnd_idx_reg) != last_idx) begin
                    key_we = 1'b1;
                    rec_we = 1'b1;
                end
                total_next      = last_idx;
                res_status_next = kqrl_pkg::ST_OK;
                state_next      = S_RESP;
            end
            S_RREC: begin
                rec_re     = 1'b1;
                state_next = S_MOD;
            end
            S_MOD: begin
                rec_waddr       = fnd_idx_reg;
                rec_wdata       = rec_mod;
                rec_we          = (op_reg != kqrl_pkg::OP_QUOTA);
                res_status_next = kqrl_pkg::ST_OK;
                state_next      = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_allowed_next = res_allowed_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        issue_reg      <= issue_next;
        cmp_idx_reg    <= cmp_idx_next;
        fnd_idx_reg    <= fnd_idx_next;
        res_status_reg <= res_status_next;
        m_status_reg   <= m_status_next;
        m_allowed_reg  <= m_allowed_next;
        if (state_reg == S_IDLE) begin
            res_allowed_reg <= 1'b0;
        end else if (state_reg == S_MOD) begin
            res_allowed_reg <= res_allowed_next;
        end
        if (s_xfer) begin
            op_reg     <= s_operation;
            key_reg    <= s_key;
            quota_reg  <= s_quota_limit;
            rate_reg   <= s_rate_limit;
            init_reg   <= s_initial_usage;
            tokens_reg <= s_tokens;
            now_reg    <= s_now_seconds;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // entry count stays within the table
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // a returning key read always belongs to a live slot
    a_scan_live: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> (CW'(cmp_idx_reg) < total_reg))
        else $error("key compare on a slot beyond the entry count");

    // an accepted item goes straight to the scan or to the response
    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == S_SRCH || state_reg == S_RESP))
        else $error("accepted item not dispatched");

    // allowed is only ever reported with a good status
    a_allowed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_allowed) |-> (m_status == kqrl_pkg::ST_OK))
        else $error("allowed set on a failed request");

endmodule

`default_nettype wire

// ===== tb/kqrl_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kqrl_scoreboard: result checker for the keyed quota and rate limit table
// Watches both channels, keeps its own copy of the key table, works out the
// status and allowed flag of every accepted request and compares each
// returned result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module kqrl_scoreboard #(
    parameter int DEPTH = kqrl_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [kqrl_pkg::OP_W-1:0]     s_operation,
    input  wire logic [kqrl_pkg::KEY_W-1:0]    s_key,
    input  wire logic [kqrl_pkg::QUOTA_W-1:0]  s_quota_limit,
    input  wire logic [kqrl_pkg::RATE_W-1:0]   s_rate_limit,
    input  wire logic [kqrl_pkg::QUOTA_W-1:0]  s_initial_usage,
    input  wire logic [kqrl_pkg::QUOTA_W-1:0]  s_tokens,
    input  wire logic [kqrl_pkg::TIME_W-1:0]   s_now_seconds,

    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [kqrl_pkg::STATUS_W-1:0] m_status,
    input  wire logic                          m_allowed,

    output int                                 fail_count,
    output int                                 pending
);

    typedef struct packed {
        logic [kqrl_pkg::STATUS_W-1:0] status;
        logic                          allowed;
    } outcome_t;

    logic [kqrl_pkg::KEY_W-1:0] table_key [DEPTH];
    kqrl_pkg::rec_t             table_rec [DEPTH];
    int                         live_total;

    outcome_t         awaited_outcomes [$];
    outcome_t         oldest;

    // apply one request to the shadow table and return its outcome
    function automatic outcome_t apply_request(
        input logic [kqrl_pkg::OP_W-1:0]    op,
        input logic [kqrl_pkg::KEY_W-1:0]   key,
        input logic [kqrl_pkg::QUOTA_W-1:0] quota,
        input logic [kqrl_pkg::RATE_W-1:0]  rate,
        input logic [kqrl_pkg::QUOTA_W-1:0] usage,
        input logic [kqrl_pkg::QUOTA_W-1:0] tokens,
        input logic [kqrl_pkg::TIME_W-1:0]  now
    );
        outcome_t                    res;
        kqrl_pkg::rec_t              rec;
        logic [kqrl_pkg::TIME_W-1:0] elapsed;
        int                          slot;
        int                          i;

        res.status  = kqrl_pkg::ST_OK;
        res.allowed = 1'b0;
        slot = -1;
        for (i = 0; i < live_total; i++)
            if (slot < 0 && table_key[i] == key)
                slot = i;

        case (op)
            kqrl_pkg::OP_CREATE: begin
                if (key == '0)
                    res.status = kqrl_pkg::ST_INVALID;
                else if (slot >= 0)
                    res.status = kqrl_pkg::ST_EXISTS;
                else if (live_total >= DEPTH)
                    res.status = kqrl_pkg::ST_FULL;
                else begin
                    rec.quota  = quota;
                    rec.usage  = usage;
                    rec.rate   = rate;
                    rec.wstart = '0;
                    rec.wcount = '0;
                    table_key[live_total] = key;
                    table_rec[live_total] = rec;
                    live_total++;
                end
            end
            kqrl_pkg::OP_DELETE, kqrl_pkg::OP_ADD, kqrl_pkg::OP_QUOTA,
            kqrl_pkg::OP_RATE: begin
                if (slot < 0)
                    res.status = kqrl_pkg::ST_NOT_FOUND;
                else if (op == kqrl_pkg::OP_DELETE) begin
                    // last entry fills the hole
                    table_key[slot] = table_key[live_total-1];
                    table_rec[slot] = table_rec[live_total-1];
                    live_total--;
                end else begin
                    rec = table_rec[slot];
                    if (op == kqrl_pkg::OP_ADD)
                        rec.usage = rec.usage + tokens;
                    else if (op == kqrl_pkg::OP_QUOTA)
                        res.allowed = (rec.quota == '0) || (rec.usage < rec.quota);
                    else if (rec.rate == '0)
                        res.allowed = 1'b1;
                    else begin
                        elapsed = now - rec.wstart;
                        if (elapsed >= kqrl_pkg::WINDOW_SECONDS) begin
                            rec.wstart = now;
                            rec.wcount = '0;
                        end
                        if (rec.wcount < rec.rate) begin
                            rec.wcount  = rec.wcount + 1'b1;
                            res.allowed = 1'b1;
                        end
                    end
                    table_rec[slot] = rec;
                end
            end
            default: res.status = kqrl_pkg::ST_INVALID;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            live_total = 0;
            awaited_outcomes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("unexpected result: status %0d allowed %0d", m_status, m_allowed);
                    fail_count++;
                end else begin
                    oldest = awaited_outcomes.pop_front();
                    if (m_status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, m_status);
                        fail_count++;
                    end
                    if (m_allowed !== oldest.allowed) begin
                        $error("allowed: expected %0d, actual %0d", oldest.allowed, m_allowed);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                awaited_outcomes.push_back(apply_request(s_operation, s_key, s_quota_limit,
                    s_rate_limit, s_initial_usage, s_tokens, s_now_seconds));
        end
        pending = awaited_outcomes.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the keyed quota and rate limit table
// Drives a directed sequence, then a random mix over a small key set, a fill
// of the whole table and a drain by deletes, with random idling on both
// channels and one long result hold-off. A scoreboard alongside the block
// predicts and checks every result; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int DEPTH      = kqrl_pkg::TABLE_DEPTH_DEF;
    localparam int POOL_KEYS  = 12;
    localparam int FILL_KEYS  = DEPTH + 4;   // a few creates beyond capacity
    localparam int SETTLE     = DEPTH + 40;  // worst search plus margin
    localparam int HOLD_OFF   = 800;         // long receiver stall, in cycles
    localparam int DRAIN_WAIT = 20000;

    logic                          aclk;
    logic                          aresetn         = 1'b0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic [kqrl_pkg::OP_W-1:0]     s_operation     = kqrl_pkg::OP_CREATE;
    logic [kqrl_pkg::KEY_W-1:0]    s_key           = '0;
    logic [kqrl_pkg::QUOTA_W-1:0]  s_quota_limit   = '0;
    logic [kqrl_pkg::RATE_W-1:0]   s_rate_limit    = '0;
    logic [kqrl_pkg::QUOTA_W-1:0]  s_initial_usage = '0;
    logic [kqrl_pkg::QUOTA_W-1:0]  s_tokens        = '0;
    logic [kqrl_pkg::TIME_W-1:0]   s_now_seconds   = '0;
    logic                          m_valid;
    logic                          m_ready         = 1'b0;
    logic [kqrl_pkg::STATUS_W-1:0] m_status;
    logic                          m_allowed;

    int                  fail_count;
    int                  pending;

    // stimulus bookkeeping
    int                          sent_count  = 0;
    bit                          quiet_tail  = 1'b0;   // no idling from here on
    bit                          held_off    = 1'b0;
    logic [kqrl_pkg::TIME_W-1:0] now_s       = '0;
    logic [kqrl_pkg::KEY_W-1:0]  key_pool   [POOL_KEYS];
    logic [kqrl_pkg::KEY_W-1:0]  fresh_keys [FILL_KEYS];
    logic [kqrl_pkg::OP_W-1:0]   op;
    logic [kqrl_pkg::KEY_W-1:0]  k;
    int                          n;
    int                          created;
    int                          waited;

    keyed_quota_and_rate_limit_table #(.TABLE_DEPTH(DEPTH)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_key           (s_key),
        .s_quota_limit   (s_quota_limit),
        .s_rate_limit    (s_rate_limit),
        .s_initial_usage (s_initial_usage),
        .s_tokens        (s_tokens),
        .s_now_seconds   (s_now_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_allowed       (m_allowed)
    );

    kqrl_scoreboard #(.DEPTH(DEPTH)) scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_key           (s_key),
        .s_quota_limit   (s_quota_limit),
        .s_rate_limit    (s_rate_limit),
        .s_initial_usage (s_initial_usage),
        .s_tokens        (s_tokens),
        .s_now_seconds   (s_now_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_allowed       (m_allowed),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // hard stop should anything hang
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Random field pickers. Mostly small values so that quotas run out and
    // rate windows fill; now and then full-width values so every bit moves.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand_wide();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [kqrl_pkg::OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18)      return kqrl_pkg::OP_CREATE;
        else if (r < 26) return kqrl_pkg::OP_DELETE;
        else if (r < 44) return kqrl_pkg::OP_ADD;
        else if (r < 62) return kqrl_pkg::OP_QUOTA;
        else if (r < 94) return kqrl_pkg::OP_RATE;
        else             return kqrl_pkg::OP_RATE +
                                kqrl_pkg::OP_W'($urandom_range(1, 3));  // unused codes
    endfunction

    function automatic logic [kqrl_pkg::QUOTA_W-1:0] pick_quota();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return rand_wide();
            default: return kqrl_pkg::QUOTA_W'($urandom_range(1, 200));
        endcase
    endfunction

    function automatic logic [kqrl_pkg::RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return kqrl_pkg::RATE_W'($urandom());
            default: return kqrl_pkg::RATE_W'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [kqrl_pkg::QUOTA_W-1:0] pick_small_or_wide(input int top);
        if ($urandom_range(0, 7) == 0)
            return rand_wide();
        return kqrl_pkg::QUOTA_W'($urandom_range(0, top));
    endfunction

    // wall clock mostly creeps forward; sometimes jumps, sometimes nears wrap
    function automatic logic [kqrl_pkg::TIME_W-1:0] next_now();
        case ($urandom_range(0, 15))
            0:       now_s = $urandom();
            1:       now_s = 32'hFFFF_FFF0 + kqrl_pkg::TIME_W'($urandom_range(0, 15));
            default: now_s = now_s + kqrl_pkg::TIME_W'($urandom_range(0, 25));
        endcase
        return now_s;
    endfunction

    // ------------------------------------------------------------------------
    // One request transfer. Valid rises with the payload and stays up until
    // the edge at which ready is seen; a random gap may follow. Called at a
    // rising edge, returns at one.
    // ------------------------------------------------------------------------
    task automatic offer(
        input logic [kqrl_pkg::OP_W-1:0]    op_i,
        input logic [kqrl_pkg::KEY_W-1:0]   key_i,
        input logic [kqrl_pkg::QUOTA_W-1:0] quota_i,
        input logic [kqrl_pkg::RATE_W-1:0]  rate_i,
        input logic [kqrl_pkg::QUOTA_W-1:0] usage_i,
        input logic [kqrl_pkg::QUOTA_W-1:0] tokens_i,
        input logic [kqrl_pkg::TIME_W-1:0]  now_i
    );
        s_valid         <= 1'b1;
        s_operation     <= op_i;
        s_key           <= key_i;
        s_quota_limit   <= quota_i;
        s_rate_limit    <= rate_i;
        s_initial_usage <= usage_i;
        s_tokens        <= tokens_i;
        s_now_seconds   <= now_i;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent_count++;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready bursts, one long hold-off early on so the
    // block backs up and stalls its input, then ready held high at the end.
    // ------------------------------------------------------------------------
    initial begin
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (!held_off && sent_count >= 60) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    initial begin
        key_pool[0] = 64'd1;
        key_pool[1] = '1;
        key_pool[2] = '0;               // never creatable, so never found
        for (n = 3; n < POOL_KEYS; n++)
            key_pool[n] = rand_wide();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed: codes, extremes and window corner cases -------------
        offer(kqrl_pkg::OP_CREATE, '0, 64'd7, 20'd1, '0, '0, '0);          // empty key
        offer(kqrl_pkg::OP_DELETE, 64'd1, '0, '0, '0, '0, '0);            // empty table
        offer(kqrl_pkg::OP_QUOTA, 64'd1, '0, '0, '0, '0, '0);
        // unlimited quota and rate
        offer(kqrl_pkg::OP_CREATE, 64'd1, '0, '0, '1, '0, '0);
        offer(kqrl_pkg::OP_CREATE, 64'd1, 64'd3, 20'd3, '0, '0, '0);      // duplicate
        offer(kqrl_pkg::OP_QUOTA, 64'd1, '0, '0, '0, '0, '0);
        offer(kqrl_pkg::OP_RATE, 64'd1, '0, '0, '0, '0, '1);
        // widest values everywhere
        offer(kqrl_pkg::OP_CREATE, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0);
        offer(kqrl_pkg::OP_QUOTA, '1, '0, '0, '0, '0, '0);
        offer(kqrl_pkg::OP_ADD, '1, '0, '0, '0, 64'd1, '0);          // usage reaches quota
        offer(kqrl_pkg::OP_QUOTA, '1, '0, '0, '0, '0, '0);
        offer(kqrl_pkg::OP_ADD, '1, '0, '0, '0, '1, '0);             // usage wraps
        offer(kqrl_pkg::OP_QUOTA, '1, '0, '0, '0, '0, '0);
        // one request per minute: window edge at 60 s and backwards time
        offer(kqrl_pkg::OP_CREATE, 64'h8000_0000_0000_0000, 64'd5, 20'd1, '0, '0, '0);
        offer(kqrl_pkg::OP_RATE, 64'h8000_0000_0000_0000, '0, '0, '0, '0, 32'd10);
        offer(kqrl_pkg::OP_RATE, 64'h8000_0000_0000_0000, '0, '0, '0, '0, 32'd59);
        offer(kqrl_pkg::OP_RATE, 64'h8000_0000_0000_0000, '0, '0, '0, '0, 32'd60);
        offer(kqrl_pkg::OP_RATE, 64'h8000_0000_0000_0000, '0, '0, '0, '0, 32'd30);
        offer(kqrl_pkg::OP_RATE, 64'h8000_0000_0000_0000, '0, '0, '0, '0, 32'd89);
        offer(kqrl_pkg::OP_ADD, 64'h8000_0000_0000_0000, '0, '0, '0, 64'd5, '0);
        offer(kqrl_pkg::OP_QUOTA, 64'h8000_0000_0000_0000, '0, '0, '0, '0, '0);
        // unused operation codes
        offer(kqrl_pkg::OP_RATE + 3'd1, 64'd1, '1, '1, '1, '1, '1);
        offer(kqrl_pkg::OP_RATE + 3'd2, 64'd1, '0, '0, '0, '0, '0);
        offer(kqrl_pkg::OP_RATE + 3'd3, '1, '1, '1, '1, '1, '1);
        // delete from the front twice (last entry moves in), a miss, then the sole entry left
        offer(kqrl_pkg::OP_DELETE, 64'd1, '0, '0, '0, '0, '0);
        offer(kqrl_pkg::OP_DELETE, 64'h8000_0000_0000_0000, '0, '0, '0, '0, '0);
        offer(kqrl_pkg::OP_DELETE, 64'h8000_0000_0000_0000, '0, '0, '0, '0, '0);
        offer(kqrl_pkg::OP_DELETE, '1, '0, '0, '0, '0, '0);

        // --- random mix over a small key set --------------------------------
        for (n = 0; n < 105; n++)
            offer(pick_op(), key_pool[$urandom_range(0, POOL_KEYS-1)], pick_quota(),
                  pick_rate(), pick_small_or_wide(100), pick_small_or_wide(60), next_now());

        // --- fill the table past capacity, with some traffic on it ----------
        created = 0;
        while (created < FILL_KEYS) begin
            if (created > 0 && $urandom_range(0, 7) == 0) begin
                k  = fresh_keys[$urandom_range(0, created-1)];
                op = ($urandom_range(0, 3) == 0) ? kqrl_pkg::OP_CREATE : pick_op();
            end else begin
                fresh_keys[created] = {$urandom() | 32'd1, 32'(created)};
                k  = fresh_keys[created];
                op = kqrl_pkg::OP_CREATE;
                created++;
            end
            offer(op, k, pick_quota(), pick_rate(), pick_small_or_wide(100),
                  pick_small_or_wide(60), next_now());
        end

        // --- drain by deletes; the last stretch runs without idling --------
        for (n = 0; n < 120; n++) begin
            if (n == 60)
                quiet_tail = 1'b1;
            if ($urandom_range(0, 9) == 0)
                k = key_pool[$urandom_range(0, POOL_KEYS-1)];
            else
                k = fresh_keys[$urandom_range(0, FILL_KEYS-1)];
            op = ($urandom_range(0, 9) < 6) ? kqrl_pkg::OP_DELETE : pick_op();
            offer(op, k, pick_quota(), pick_rate(), pick_small_or_wide(100),
                  pick_small_or_wide(60), next_now());
        end
        s_valid <= 1'b0;

        // wait for the outstanding results, sampled away from the clock edge
        waited = 0;
        @(negedge aclk);
        while (pending != 0 && waited < DRAIN_WAIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (SETTLE) @(posedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/kqrl_pkg.sv
hdl/kqrl_ram.sv
hdl/keyed_quota_and_rate_limit_table.sv
tb/kqrl_scoreboard.sv
tb/tb_top.sv
